@@ sv/uart_rf_pkg.sv @@
// Shared types and constants for the 16550-style UART register file.
// Used by uart_rf_ctrl and uart_16550_register_file; no dependencies.
package uart_rf_pkg;

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_LINE  = 2'd2;

   localparam logic [2:0] OFF_DATA    = 3'd0;
   localparam logic [2:0] OFF_IER     = 3'd1;
   localparam logic [2:0] OFF_IIR_FCR = 3'd2;
   localparam logic [2:0] OFF_LCR     = 3'd3;
   localparam logic [2:0] OFF_MCR     = 3'd4;
   localparam logic [2:0] OFF_LSR     = 3'd5;
   localparam logic [2:0] OFF_MSR     = 3'd6;
   localparam logic [2:0] OFF_SCR     = 3'd7;

   localparam int DLAB_BIT     = 7;
   localparam int LOOP_BIT     = 4;
   localparam int FCR_EN_BIT   = 0;
   localparam int FCR_RXCLR_BIT = 1;

   localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
   localparam logic [7:0] IIR_VALUE    = 8'h01;
   localparam logic [7:0] MSR_VALUE    = 8'h00;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [15:0] baud_divisor;
      logic        dtr_out;
      logic        rts_out;
   } result_type;

endpackage

@@ sv/uart_rf_rx_ram.sv @@
// Receive byte store: one write port, one registered read port.
// Standalone; instantiated by uart_16550_register_file.
module uart_rf_rx_ram #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [7:0]                          wr_data,
   input  logic                                rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [7:0]                          rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/uart_rf_ctrl.sv @@
// Register decode, control registers and receive store pointers.
// Depends on uart_rf_pkg; drives the ports of uart_rf_rx_ram.
module uart_rf_ctrl
   import uart_rf_pkg::*;
#(
   parameter int RX_DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      accept,
   input  logic [1:0]                                func,
   input  logic [2:0]                                reg_offset,
   input  logic [7:0]                                data_in,
   output result_type                                result,
   output logic                                      pop,
   output logic                                      wr_en,
   output logic [(RX_DEPTH > 1 ? $clog2(RX_DEPTH) : 1)-1:0] wr_addr,
   output logic [7:0]                                wr_data,
   output logic [(RX_DEPTH > 1 ? $clog2(RX_DEPTH) : 1)-1:0] rd_addr,
   output logic                                      fifo_on,
   output logic [$clog2(RX_DEPTH + 1)-1:0]           rx_count
);

   localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int CW = $clog2(RX_DEPTH + 1);

   logic [7:0]    lcr_ff, lcr_in;
   logic [3:0]    ier_ff, ier_in;
   logic [4:0]    mcr_ff, mcr_in;
   logic [7:0]    scr_ff, scr_in;
   logic [15:0]   div_ff, div_in;
   logic          fifo_on_ff, fifo_on_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovr_ff, ovr_in;

   logic          dlab;
   logic          loop;
   logic          push;
   logic          full;
   logic [CW:0]   tail_sum;
   logic [AW-1:0] tail;
   logic [AW-1:0] head_next;

   always_comb begin
      tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      if (tail_sum >= (CW+1)'(RX_DEPTH)) begin
         tail_sum = tail_sum - (CW+1)'(RX_DEPTH);
      end
      tail      = AW'(tail_sum);
      head_next = (head_ff == AW'(RX_DEPTH - 1)) ? '0 : head_ff + AW'(1);
      full      = fifo_on_ff ? (count_ff == CW'(RX_DEPTH)) : (count_ff != '0);
      dlab      = lcr_ff[DLAB_BIT];
      loop      = mcr_ff[LOOP_BIT];
   end

   always_comb begin
      lcr_in     = lcr_ff;
      ier_in     = ier_ff;
      mcr_in     = mcr_ff;
      scr_in     = scr_ff;
      div_in     = div_ff;
      fifo_on_in = fifo_on_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      ovr_in     = ovr_ff;
      push       = 1'b0;
      pop        = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = tail;
      result     = '0;
      if (accept) begin
         unique case (func)
            FUNC_READ: begin
               unique case (reg_offset)
                  OFF_DATA: begin
                     if (dlab) begin
                        result.read_data = div_ff[7:0];
                     end else if (count_ff != '0) begin
                        pop      = 1'b1;
                        head_in  = head_next;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OFF_IER: begin
                     result.read_data = dlab ? div_ff[15:8] : {4'b0, ier_ff};
                  end
                  OFF_IIR_FCR: result.read_data = IIR_VALUE;
                  OFF_LCR:     result.read_data = lcr_ff;
                  OFF_MCR:     result.read_data = {3'b0, mcr_ff};
                  OFF_LSR: begin
                     result.read_data = LSR_TX_EMPTY | {6'b0, ovr_ff, count_ff != '0};
                     ovr_in           = 1'b0;
                  end
                  OFF_MSR:     result.read_data = MSR_VALUE;
                  OFF_SCR:     result.read_data = scr_ff;
               endcase
            end
            FUNC_WRITE: begin
               unique case (reg_offset)
                  OFF_DATA: begin
                     if (dlab) begin
                        div_in[7:0] = data_in;
                     end else if (loop) begin
                        push = 1'b1;
                     end else begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = data_in;
                     end
                  end
                  OFF_IER: begin
                     if (dlab) begin
                        div_in[15:8] = data_in;
                     end else begin
                        ier_in = data_in[3:0];
                     end
                  end
                  OFF_IIR_FCR: begin
                     if ((data_in[FCR_EN_BIT] != fifo_on_ff) || data_in[FCR_RXCLR_BIT]) begin
                        head_in  = '0;
                        count_in = '0;
                     end
                     fifo_on_in = data_in[FCR_EN_BIT];
                  end
                  OFF_LCR: lcr_in = data_in;
                  OFF_MCR: mcr_in = data_in[4:0];
                  OFF_SCR: scr_in = data_in;
                  OFF_LSR, OFF_MSR: ;
               endcase
            end
            FUNC_LINE: push = !loop;
            default: ;
         endcase
      end
      if (push) begin
         if (full) begin
            ovr_in = 1'b1;
            if (!fifo_on_ff && (count_ff != '0)) begin
               wr_en   = 1'b1;
               wr_addr = head_ff;
            end
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
      end
      result.baud_divisor = div_in;
      result.dtr_out      = mcr_in[0];
      result.rts_out      = mcr_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcr_ff     <= '0;
         ier_ff     <= '0;
         mcr_ff     <= '0;
         scr_ff     <= '0;
         div_ff     <= '0;
         fifo_on_ff <= 1'b0;
         head_ff    <= '0;
         count_ff   <= '0;
         ovr_ff     <= 1'b0;
      end else begin
         lcr_ff     <= lcr_in;
         ier_ff     <= ier_in;
         mcr_ff     <= mcr_in;
         scr_ff     <= scr_in;
         div_ff     <= div_in;
         fifo_on_ff <= fifo_on_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         ovr_ff     <= ovr_in;
      end
   end

   assign wr_data  = data_in;
   assign rd_addr  = head_ff;
   assign fifo_on  = fifo_on_ff;
   assign rx_count = count_ff;

endmodule

@@ sv/uart_16550_register_file.sv @@
// Top level of the 16550-style UART register file.
// Depends on uart_rf_pkg, uart_rf_ctrl and uart_rf_rx_ram.
//
// Takes one beat per cycle while req_stall is low (bus read, bus write or
// received line byte) and returns one result beat for each. The accepting edge
// performs the register update and the synchronous read of the receive store;
// the output register loads from the read stage once it is free and drives rsp_valid.
// Received bytes live in an RX_DEPTH-entry memory with one write and one
// registered read port; a receive-buffer read returns the byte read from that
// port. Entries start undefined, so no clearing pass is needed after reset.
// A stalled result still lets one more beat in before req_stall rises.
module uart_16550_register_file
   import uart_rf_pkg::*;
#(
   parameter int RX_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_reg_offset,
   input  logic [7:0]  req_data_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic [15:0] rsp_baud_divisor,
   output logic        rsp_dtr_out,
   output logic        rsp_rts_out
);

   localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int CW = $clog2(RX_DEPTH + 1);

   logic          accept;
   logic          out_free;
   logic          s1_advance;
   result_type    ctrl_result;
   logic          ctrl_pop;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rx_rd_data;
   logic          fifo_on;
   logic [CW-1:0] rx_count;

   logic          s1_valid_ff, s1_valid_in;
   result_type    s1_result_ff;
   logic          s1_pop_ff;
   logic          out_valid_ff, out_valid_in;
   result_type    out_result_ff;
   result_type    s1_merged;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign accept     = req_valid && !req_stall;

   uart_rf_ctrl #(
      .RX_DEPTH (RX_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .func       (req_func),
      .reg_offset (req_reg_offset),
      .data_in    (req_data_in),
      .result     (ctrl_result),
      .pop        (ctrl_pop),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .fifo_on    (fifo_on),
      .rx_count   (rx_count)
   );

   uart_rf_rx_ram #(
      .DEPTH (RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rx_rd_data)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_advance);
      out_valid_in = s1_advance || (out_valid_ff && rsp_stall);
      s1_merged    = s1_result_ff;
      if (s1_pop_ff) begin
         s1_merged.read_data = rx_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff <= ctrl_result;
         s1_pop_ff    <= ctrl_pop;
      end
      if (s1_advance) begin
         out_result_ff <= s1_merged;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_result_ff.read_data;
   assign rsp_tx_valid     = out_result_ff.tx_valid;
   assign rsp_tx_byte      = out_result_ff.tx_byte;
   assign rsp_baud_divisor = out_result_ff.baud_divisor;
   assign rsp_dtr_out      = out_result_ff.dtr_out;
   assign rsp_rts_out      = out_result_ff.rts_out;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count <= CW'(RX_DEPTH))
      else $error("receive count exceeds store depth");

   a_single_hold: assert property (@(posedge clock) disable iff (reset)
      !fifo_on |-> rx_count <= CW'(1))
      else $error("receive count above one with fifo disabled");

   a_s1_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff)
      else $error("pending beat dropped from read stage");

   a_tx_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'd0)
      else $error("transmit byte nonzero without transmit valid");

endmodule

@@ tb/uart_16550_register_file_tb.sv @@
// Self-checking testbench for uart_16550_register_file: directed and random bus and line beats,
// each result compared with a cycle-free model of the 16550 register map and receive store.
// Depends on uart_rf_pkg and uart_16550_register_file.
module uart_16550_register_file_tb;
   import uart_rf_pkg::*;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int RX_DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int BEATS_PER_PHASE = 560;

   typedef struct {
      logic [1:0] func;
      logic [2:0] off;
      logic [7:0] data;
      bit         drain;
      int         phase;
   } uart_beat_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_READ;
   logic [2:0]  req_reg_offset = OFF_DATA;
   logic [7:0]  req_data_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic [15:0] rsp_baud_divisor;
   logic        rsp_dtr_out;
   logic        rsp_rts_out;

   uart_beat_t beat_q[$];
   result_type expected_q[$];
   int send_idle_pct[3] = '{31, 46, 0};
   int recv_idle_pct[3] = '{46, 31, 0};
   int rsp_idle_pct = 0;
   int mismatches = 0;
   int cycles = 0;
   int gen_phase = 0;
   bit gen_drain = 1'b0;

   logic [7:0]  line_ctl = 8'h00;
   logic [3:0]  ier_bits = 4'h0;
   logic [4:0]  mcr_bits = 5'h00;
   logic [7:0]  scratch = 8'h00;
   logic [15:0] divisor = 16'h0000;
   logic        fifo_en = 1'b0;
   logic [7:0]  rx_mem[RX_DEPTH];
   int          rx_rd_ptr = 0;
   int          rx_fill = 0;
   logic        rx_overrun = 1'b0;

   uart_16550_register_file u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_reg_offset   (req_reg_offset),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_tx_valid     (rsp_tx_valid),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_baud_divisor (rsp_baud_divisor),
      .rsp_dtr_out      (rsp_dtr_out),
      .rsp_rts_out      (rsp_rts_out)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic rx_enqueue(input logic [7:0] b);
      int cap;
      cap = fifo_en ? RX_DEPTH : 1;
      if (rx_fill >= cap) begin
         rx_overrun = 1'b1;
         if (!fifo_en && rx_fill > 0)
            rx_mem[rx_rd_ptr] = b;
      end else begin
         rx_mem[(rx_rd_ptr + rx_fill) % RX_DEPTH] = b;
         rx_fill++;
      end
   endtask

   task automatic predict_uart(input logic [1:0] func, input logic [2:0] off,
                               input logic [7:0] d, output result_type r);
      logic dlab;
      dlab = line_ctl[DLAB_BIT];
      r = '0;
      if (func == FUNC_READ) begin
         case (off)
            OFF_DATA: begin
               if (dlab) begin
                  r.read_data = divisor[7:0];
               end else if (rx_fill > 0) begin
                  r.read_data = rx_mem[rx_rd_ptr];
                  rx_rd_ptr = (rx_rd_ptr + 1) % RX_DEPTH;
                  rx_fill--;
               end
            end
            OFF_IER:     r.read_data = dlab ? divisor[15:8] : {4'h0, ier_bits};
            OFF_IIR_FCR: r.read_data = IIR_VALUE;
            OFF_LCR:     r.read_data = line_ctl;
            OFF_MCR:     r.read_data = {3'b000, mcr_bits};
            OFF_LSR: begin
               r.read_data = LSR_TX_EMPTY | {6'b0, rx_overrun, rx_fill > 0};
               rx_overrun = 1'b0;
            end
            OFF_MSR:     r.read_data = MSR_VALUE;
            default:     r.read_data = scratch;
         endcase
      end else if (func == FUNC_WRITE) begin
         case (off)
            OFF_DATA: begin
               if (dlab) begin
                  divisor[7:0] = d;
               end else if (mcr_bits[LOOP_BIT]) begin
                  rx_enqueue(d);
               end else begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = d;
               end
            end
            OFF_IER: begin
               if (dlab)
                  divisor[15:8] = d;
               else
                  ier_bits = d[3:0];
            end
            OFF_IIR_FCR: begin
               if (d[FCR_EN_BIT] != fifo_en || d[FCR_RXCLR_BIT]) begin
                  rx_rd_ptr = 0;
                  rx_fill = 0;
               end
               fifo_en = d[FCR_EN_BIT];
            end
            OFF_LCR: line_ctl = d;
            OFF_MCR: mcr_bits = d[4:0];
            OFF_SCR: scratch = d;
            default: ;
         endcase
      end else if (func == FUNC_LINE && !mcr_bits[LOOP_BIT]) begin
         rx_enqueue(d);
      end
      r.baud_divisor = divisor;
      r.dtr_out = mcr_bits[0];
      r.rts_out = mcr_bits[1];
   endtask

   task automatic queue_beat(input logic [1:0] f, input logic [2:0] o, input logic [7:0] d);
      uart_beat_t b;
      b.func = f;
      b.off = o;
      b.data = d;
      b.drain = gen_drain;
      b.phase = gen_phase;
      gen_drain = 1'b0;
      beat_q.push_back(b);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : drive
      uart_beat_t nxt;
      result_type exp_r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_uart(req_func, req_reg_offset, req_data_in, exp_r);
            expected_q.push_back(exp_r);
         end
         if (!req_valid || !req_stall) begin
            if (beat_q.size() > 0 && !(beat_q[0].drain && expected_q.size() > 0) &&
                $urandom_range(99) >= send_idle_pct[beat_q[0].phase]) begin
               nxt = beat_q.pop_front();
               req_valid <= 1'b1;
               req_func <= nxt.func;
               req_reg_offset <= nxt.off;
               req_data_in <= nxt.data;
               rsp_idle_pct <= recv_idle_pct[nxt.phase];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result beat with nothing expected");
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               check_field("read_data", 16'(want.read_data), 16'(rsp_read_data));
               check_field("tx_valid", 16'(want.tx_valid), 16'(rsp_tx_valid));
               check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_tx_byte));
               check_field("baud_divisor", want.baud_divisor, rsp_baud_divisor);
               check_field("dtr_out", 16'(want.dtr_out), 16'(rsp_dtr_out));
               check_field("rts_out", 16'(want.rts_out), 16'(rsp_rts_out));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("uart_16550_register_file: mismatch");
         $finish;
      end
   end

   initial begin
      int sel;
      logic [1:0] f;
      logic [2:0] o;
      logic [7:0] d;

      // fill every store entry once, overrun the full FIFO, then drain it
      queue_beat(FUNC_WRITE, OFF_IIR_FCR, 8'h01);
      for (int i = 0; i < RX_DEPTH + 1; i++)
         queue_beat(FUNC_LINE, 3'($urandom_range(7)),
                    (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
      queue_beat(FUNC_READ, OFF_LSR, 8'h00);
      for (int i = 0; i < RX_DEPTH + 1; i++)
         queue_beat(FUNC_READ, OFF_DATA, 8'h00);

      queue_beat(FUNC_WRITE, OFF_LCR, 8'h80);
      queue_beat(FUNC_WRITE, OFF_DATA, 8'hFF);
      queue_beat(FUNC_WRITE, OFF_IER, 8'hFF);
      queue_beat(FUNC_READ, OFF_DATA, 8'h00);
      queue_beat(FUNC_READ, OFF_IER, 8'h00);
      queue_beat(FUNC_WRITE, OFF_IER, 8'h00);
      queue_beat(FUNC_WRITE, OFF_DATA, 8'h00);
      queue_beat(FUNC_WRITE, OFF_LCR, 8'h03);
      queue_beat(FUNC_READ, OFF_LCR, 8'h00);
      queue_beat(FUNC_WRITE, OFF_IER, 8'hFF);
      queue_beat(FUNC_READ, OFF_IER, 8'h00);
      queue_beat(FUNC_WRITE, OFF_MCR, 8'hFF);
      queue_beat(FUNC_READ, OFF_MCR, 8'h00);
      queue_beat(FUNC_WRITE, OFF_DATA, 8'h5A);
      queue_beat(FUNC_LINE, OFF_DATA, 8'h77);
      queue_beat(FUNC_READ, OFF_DATA, 8'h00);
      queue_beat(FUNC_WRITE, OFF_MCR, 8'h03);
      queue_beat(FUNC_WRITE, OFF_DATA, 8'hA5);
      queue_beat(FUNC_WRITE, OFF_LSR, 8'hFF);
      queue_beat(FUNC_WRITE, OFF_MSR, 8'hFF);
      queue_beat(FUNC_READ, OFF_LSR, 8'h00);
      queue_beat(FUNC_READ, OFF_MSR, 8'h00);
      queue_beat(FUNC_READ, OFF_IIR_FCR, 8'h00);
      queue_beat(FUNC_WRITE, OFF_SCR, 8'hFF);
      queue_beat(FUNC_READ, OFF_SCR, 8'h00);
      queue_beat(FUNC_WRITE, OFF_IIR_FCR, 8'h00);
      queue_beat(FUNC_LINE, OFF_DATA, 8'h11);
      queue_beat(FUNC_LINE, OFF_DATA, 8'h22);
      queue_beat(FUNC_READ, OFF_LSR, 8'h00);
      queue_beat(FUNC_READ, OFF_DATA, 8'h00);
      queue_beat(FUNC_WRITE, OFF_IIR_FCR, 8'h07);
      queue_beat(FUNC_LINE, OFF_DATA, 8'h33);
      queue_beat(FUNC_WRITE, OFF_IIR_FCR, 8'h03);
      queue_beat(FUNC_NONE, OFF_SCR, 8'hFF);
      queue_beat(FUNC_READ, OFF_DATA, 8'h00);

      for (int ph = 0; ph < 3; ph++) begin
         gen_phase = ph;
         gen_drain = 1'b1;
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            sel = $urandom_range(99);
            o = 3'($urandom_range(7));
            d = 8'($urandom);
            if (sel < 35) begin
               f = FUNC_READ;
               if ($urandom_range(9) < 4)
                  o = OFF_DATA;
            end else if (sel < 70) begin
               f = FUNC_WRITE;
               case (o)
                  OFF_LCR:     d[DLAB_BIT] = ($urandom_range(3) == 0);
                  OFF_MCR:     d[LOOP_BIT] = ($urandom_range(4) == 0);
                  OFF_IIR_FCR: begin
                     d[FCR_EN_BIT] = ($urandom_range(6) != 0);
                     d[FCR_RXCLR_BIT] = ($urandom_range(9) == 0);
                  end
                  default: ;
               endcase
            end else if (sel < 95) begin
               f = FUNC_LINE;
            end else begin
               f = FUNC_NONE;
            end
            queue_beat(f, o, d);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (beat_q.size() > 0 || req_valid || expected_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("uart_16550_register_file: match");
      else
         $display("uart_16550_register_file: mismatch");
      $finish;
   end

endmodule
